/* hw/rtl/circular_deque_assert.svh */
// assertion macros shared by the deque checker
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

// property checked on every clock edge outside reset
`define CD_ASSERT(name, prop) \
   name: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("circular_deque assertion failed");

// property checked on every clock edge, reset included
`define CD_ASSERT_ALWAYS(name, prop) \
   name: assert property (@(posedge clock) prop) \
      else $error("circular_deque assertion failed");

`endif

/* hw/rtl/cd_pkg.sv */
// shared types and constants of the circular deque
package cd_pkg;

   localparam int STORE_DEPTH_DEF = 128;
   localparam int DATA_W          = 32;
   localparam int CAP_W           = 8;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

   // register index, taken from the word address
   localparam logic [0:0] REG_CAPACITY = 1'b0;

   typedef enum logic [1:0] {
      MODE_PUSH_REAR  = 2'd0,
      MODE_POP_FRONT  = 2'd1,
      MODE_PUSH_FRONT = 2'd2,
      MODE_POP_REAR   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   // what travels with an item from the control stage to the result stage
   typedef struct packed {
      logic       pop_ok;
      status_type status;
   } item_info_type;

endpackage

/* hw/rtl/cd_csr.sv */
// configuration register block with the capacity register
module cd_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [cd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready,
   output logic [cd_pkg::CAP_W-1:0]      capacity
);
   import cd_pkg::*;

   logic [CAP_W-1:0] cap_ff;
   logic             wr_cap;
   logic             sel_cap;

   // register decode on the word address
   assign sel_cap = (csr_paddr[CSR_ADDR_W-1:2] == REG_CAPACITY);
   assign wr_cap  = csr_psel && csr_penable && csr_pwrite && sel_cap;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (wr_cap) begin
         cap_ff <= csr_pwdata[CAP_W-1:0];
      end
   end

   // read back
   always_comb begin
      csr_prdata = '0;
      if (sel_cap) begin
         csr_prdata = {{(CSR_DATA_W-CAP_W){1'b0}}, cap_ff};
      end
   end

   assign csr_pready = 1'b1;
   assign capacity   = cap_ff;

endmodule

/* hw/rtl/cd_store.sv */
// slot memory, one port, registered read data
module cd_store #(
   parameter int DEPTH = cd_pkg::STORE_DEPTH_DEF,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic                          rd_en,
   input  logic [IDX_W-1:0]              addr,
   input  logic signed [cd_pkg::DATA_W-1:0] wr_data,
   output logic signed [cd_pkg::DATA_W-1:0] rd_data
);
   import cd_pkg::*;

   logic signed [DATA_W-1:0] mem [DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/cd_ctrl.sv */
// end pointers, full and empty tests, memory access for each item
module cd_ctrl #(
   parameter int DEPTH = cd_pkg::STORE_DEPTH_DEF,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  cd_pkg::mode_type                 mode,
   input  logic signed [cd_pkg::DATA_W-1:0] push_value,
   input  logic [cd_pkg::CAP_W-1:0]         capacity,
   output logic                             mem_wr_en,
   output logic                             mem_rd_en,
   output logic [IDX_W-1:0]                 mem_addr,
   output logic signed [cd_pkg::DATA_W-1:0] mem_wr_data,
   output cd_pkg::item_info_type            info
);
   import cd_pkg::*;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

   logic [IDX_W-1:0] front_ff, front_in;
   logic [IDX_W-1:0] rear_ff, rear_in;
   logic             empty_ff, empty_in;

   logic [IDX_W-1:0] cap_m1;
   logic [31:0]      cap_wide;
   logic             full;
   logic             one_left;
   logic [IDX_W-1:0] next_rear, prev_front, next_front, prev_rear;
   logic             mem_wr, mem_rd;

   // effective capacity minus one: zero acts as one, oversize as the depth
   always_comb begin
      cap_wide = {{(32-CAP_W){1'b0}}, capacity};
      if (capacity == '0) begin
         cap_m1 = '0;
      end else if (cap_wide > 32'(DEPTH)) begin
         cap_m1 = IDX_LAST;
      end else begin
         cap_m1 = IDX_W'(cap_wide - 32'd1);
      end
   end

   // pointer steps with wraparound inside the capacity
   assign next_rear  = (rear_ff >= cap_m1) ? '0 : rear_ff + 1'b1;
   assign next_front = (front_ff >= cap_m1) ? '0 : front_ff + 1'b1;
   assign prev_front = (front_ff == '0) ? cap_m1 : front_ff - 1'b1;
   assign prev_rear  = (rear_ff == '0) ? cap_m1 : rear_ff - 1'b1;

   // full test, the adjacency compare one bit wider so the top slot does not alias
   assign full = !empty_ff &&
      (((front_ff == '0) && (rear_ff == cap_m1)) ||
       ({1'b0, front_ff} == ({1'b0, rear_ff} + 1'b1)));
   assign one_left = (front_ff == rear_ff);

   // operation decode
   always_comb begin
      front_in    = front_ff;
      rear_in     = rear_ff;
      empty_in    = empty_ff;
      mem_wr      = 1'b0;
      mem_rd      = 1'b0;
      mem_addr    = '0;
      info.pop_ok = 1'b0;
      info.status = ST_DONE;
      unique case (mode)
         MODE_PUSH_REAR, MODE_PUSH_FRONT: begin
            if (full) begin
               info.status = ST_OVERFLOW;
            end else if (empty_ff) begin
               front_in = '0;
               rear_in  = '0;
               empty_in = 1'b0;
               mem_wr   = 1'b1;
               mem_addr = '0;
            end else if (mode == MODE_PUSH_REAR) begin
               rear_in  = next_rear;
               mem_wr   = 1'b1;
               mem_addr = next_rear;
            end else begin
               front_in = prev_front;
               mem_wr   = 1'b1;
               mem_addr = prev_front;
            end
         end
         MODE_POP_FRONT, MODE_POP_REAR: begin
            if (empty_ff) begin
               info.status = ST_UNDERFLOW;
            end else begin
               info.pop_ok = 1'b1;
               mem_rd      = 1'b1;
               mem_addr    = (mode == MODE_POP_FRONT) ? front_ff : rear_ff;
               if (one_left) begin
                  front_in = '0;
                  rear_in  = '0;
                  empty_in = 1'b1;
               end else if (mode == MODE_POP_FRONT) begin
                  front_in = next_front;
               end else begin
                  rear_in = prev_rear;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign mem_wr_en   = accept && mem_wr;
   assign mem_rd_en   = accept && mem_rd;
   assign mem_wr_data = push_value;

   // pointer state
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         rear_ff  <= '0;
         empty_ff <= 1'b1;
      end else if (accept) begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
         empty_ff <= empty_in;
      end
   end

endmodule

/* hw/rtl/cd_resp.sv */
// read-data stage and output register of the result channel
module cd_resp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  cd_pkg::item_info_type            info,
   input  logic signed [cd_pkg::DATA_W-1:0] rd_data,
   output logic                             take_ready,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [cd_pkg::DATA_W-1:0] rsp_pop_value,
   output logic [1:0]                       rsp_status
);
   import cd_pkg::*;

   logic                     s1_valid_ff, s1_valid_in;
   item_info_type            s1_info_ff;
   logic                     out_valid_ff, out_valid_in;
   logic signed [DATA_W-1:0] out_value_ff;
   status_type               out_status_ff;
   logic                     out_free;
   logic                     move;

   // handshake between the read stage and the output register
   assign out_free     = !out_valid_ff || rsp_ready;
   assign move         = s1_valid_ff && out_free;
   assign take_ready   = !s1_valid_ff || out_free;
   assign s1_valid_in  = accept || (s1_valid_ff && !move);
   assign out_valid_in = move || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // item payloads
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff <= info;
      end
      if (move) begin
         out_value_ff  <= s1_info_ff.pop_ok ? rd_data : '0;
         out_status_ff <= s1_info_ff.status;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_pop_value = out_value_ff;
   assign rsp_status    = out_status_ff;

endmodule

/* hw/rtl/circular_deque.sv */
// circular deque top level
//
//  channel  direction  payload                     handshake
//  req_     in         mode, push_value            req_valid / req_ready
//  rsp_     out        pop_value, status           rsp_valid / rsp_ready
//  csr_     in/out     capacity at byte address 0  psel / penable / pwrite, pready high
//
// one item per cycle while req_ready is high; each successful item reads or writes
// the slot memory once at acceptance; results pass the read register, then output register
// req_ready drops only when the read stage and the output register are both full
// and the waiting result is not taken in that cycle
// synchronous reset empties the deque and sets capacity to 128; slot contents are kept
module circular_deque #(
   parameter int STORE_DEPTH = cd_pkg::STORE_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_mode,
   input  logic signed [cd_pkg::DATA_W-1:0] req_push_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [cd_pkg::DATA_W-1:0] rsp_pop_value,
   output logic [1:0]                       rsp_status,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [cd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [cd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [cd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                             csr_pready
);
   import cd_pkg::*;

   localparam int IDX_W = $clog2(STORE_DEPTH);

   logic                     accept;
   logic [CAP_W-1:0]         capacity;
   logic                     mem_wr_en;
   logic                     mem_rd_en;
   logic [IDX_W-1:0]         mem_addr;
   logic signed [DATA_W-1:0] mem_wr_data;
   logic signed [DATA_W-1:0] mem_rd_data;
   item_info_type            info;
   mode_type                 mode;

   assign mode   = mode_type'(req_mode);
   assign accept = req_valid && req_ready;

   cd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .capacity    (capacity)
   );

   cd_ctrl #(
      .DEPTH (STORE_DEPTH),
      .IDX_W (IDX_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .mode        (mode),
      .push_value  (req_push_value),
      .capacity    (capacity),
      .mem_wr_en   (mem_wr_en),
      .mem_rd_en   (mem_rd_en),
      .mem_addr    (mem_addr),
      .mem_wr_data (mem_wr_data),
      .info        (info)
   );

   cd_store #(
      .DEPTH (STORE_DEPTH),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (mem_rd_en),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   cd_resp u_resp (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .info          (info),
      .rd_data       (mem_rd_data),
      .take_ready    (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pop_value (rsp_pop_value),
      .rsp_status    (rsp_status)
   );

endmodule

/* hw/rtl/cd_checker.sv */
// port-level checker of the circular deque and its bind
`include "circular_deque_assert.svh"

module cd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic signed [cd_pkg::DATA_W-1:0] rsp_pop_value,
   input logic [1:0]                       rsp_status
);
   import cd_pkg::*;

   // a result waiting to be taken stays offered
   `CD_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid)

   // reset leaves no result pending
   `CD_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid)

   // only the three defined status codes appear
   `CD_ASSERT(a_status_code, rsp_valid |-> ((rsp_status == ST_DONE) || (rsp_status == ST_OVERFLOW) || (rsp_status == ST_UNDERFLOW)))

   // a failed operation carries a zero value
   `CD_ASSERT(a_fail_zero, rsp_valid && (rsp_status != ST_DONE) |-> (rsp_pop_value == '0))

endmodule

bind circular_deque cd_checker u_cd_checker (.*);
